// ----- hdl/hbs_pkg.sv -----
// Shared types, constants and arithmetic helpers of the heightmap bilinear sampler.
package hbs_pkg;

    localparam int MAX_SIDE = 256;
    localparam int IDX_W    = $clog2(MAX_SIDE);
    localparam int DIM_W    = IDX_W + 1;
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;

    localparam int H_W      = 32;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = 64;
    localparam int P_W      = PROD_W - FRAC_W + 1;
    localparam int IP_W     = P_W - FRAC_W;
    localparam int CI_W     = IP_W + 1;
    localparam int SC_W     = PROD_W - FRAC_W;
    localparam int SCD_W    = SC_W + 1;
    localparam int LM_W     = SCD_W + FRAC_W + 1;
    localparam int D_W      = H_W + 1;

    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam int PORT_SLOTS = 4;
    localparam int GAP_W      = $clog2(PORT_SLOTS);
    localparam int RESULT_LAT = 17;

    localparam logic [H_W-1:0] INV_CELL_RST = 32'h0001_0000;
    localparam logic [H_W-1:0] GAIN_RST     = 32'h0001_0000;
    localparam logic [H_W-1:0] OFFSET_RST   = 32'h0000_0000;

    typedef enum logic [0:0] {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd;

    // neighbour read order: lower row first, lower column first
    typedef enum logic [1:0] {
        NB_X0Y0 = 2'd0,
        NB_X1Y0 = 2'd1,
        NB_X0Y1 = 2'd2,
        NB_X1Y1 = 2'd3
    } t_nb;

    typedef enum logic [2:0] {
        REG_INV_CELL_SIZE = 3'd0,
        REG_VERTICAL_GAIN = 3'd1,
        REG_HEIGHT_OFFSET = 3'd2,
        REG_GRID_WIDTH    = 3'd3,
        REG_GRID_HEIGHT   = 3'd4
    } t_reg;

    typedef struct packed {
        t_nb               idx;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
    } t_tag;

    typedef struct packed {
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic [FRAC_W-1:0] frac;
    } t_loc;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d < DIM_W'(2)) begin
            r = DIM_W'(2);
        end else if (d > DIM_W'(MAX_SIDE)) begin
            r = DIM_W'(MAX_SIDE);
        end else begin
            r = d;
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] clamp_idx(input logic signed [CI_W-1:0] i,
                                                   input logic [DIM_W-1:0] dim);
        logic [DIM_W-1:0] dm1;
        logic [IDX_W-1:0] r;
        dm1 = dim - DIM_W'(1);
        if (i < 0) begin
            r = '0;
        end else if (i > $signed({{(CI_W-DIM_W){1'b0}}, dm1})) begin
            r = dm1[IDX_W-1:0];
        end else begin
            r = i[IDX_W-1:0];
        end
        return r;
    endfunction

    // floor of the scaled position plus half the grid, split into clamped indices
    function automatic t_loc locate(input logic signed [PROD_W-1:0] prod,
                                    input logic [DIM_W-1:0] dim);
        logic signed [P_W-1:0]  p;
        logic signed [IP_W-1:0] ip;
        logic signed [CI_W-1:0] ip_ext;
        logic signed [CI_W-1:0] hi_raw;
        logic [FRAC_W-1:0]      f;
        t_loc                   r;
        p      = $signed({prod[PROD_W-1], prod[PROD_W-1:FRAC_W]})
               + $signed({{(P_W-IDX_W-FRAC_W){1'b0}}, dim[DIM_W-1:1], {FRAC_W{1'b0}}});
        ip     = p[P_W-1:FRAC_W];
        f      = p[FRAC_W-1:0];
        ip_ext = CI_W'(ip);
        hi_raw = ip_ext + $signed({{(CI_W-1){1'b0}}, |f});
        r.frac = f;
        r.lo   = clamp_idx(ip_ext, dim);
        r.hi   = clamp_idx(hi_raw, dim);
        return r;
    endfunction

    // round to nearest, ties upward, after a*2^16 + (b-a)*f
    function automatic logic signed [SC_W-1:0] lerp_round(input logic signed [SC_W-1:0] a,
                                                          input logic signed [LM_W-1:0] m);
        logic signed [LM_W-1:0] s;
        s = (LM_W'(a) <<< FRAC_W) + m + $signed(LM_W'(1) << (FRAC_W - 1));
        return s[SC_W+FRAC_W-1:FRAC_W];
    endfunction

    function automatic logic signed [H_W-1:0] sat_h(input logic signed [SC_W-1:0] v);
        logic signed [H_W-1:0] r;
        if (v > $signed(SC_W'({1'b0, {(H_W-1){1'b1}}}))) begin
            r = {1'b0, {(H_W-1){1'b1}}};
        end else if (v < -$signed(SC_W'({1'b1, {(H_W-1){1'b0}}}))) begin
            r = {1'b1, {(H_W-1){1'b0}}};
        end else begin
            r = v[H_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/hbs_ram.sv -----
// Generic single-port RAM with registered read.
module hbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end else if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/heightmap_bilinear_sampler.sv -----
// Heightmap bilinear sampler: grid memory, position mapping, scaling and blending pipeline.
//
//  channel   | direction | transfer                               | payload
//  ----------+-----------+----------------------------------------+---------------------------
//  command   | in        | start high, busy low at the clock edge | i_command, i_cell_*, i_query_*
//  result    | out       | o_sampled_valid high for one cycle     | o_sampled_height
//  config    | in/out    | psel, penable, pwrite, pready high     | paddr, pwdata, prdata
//
// A write uses the grid memory port once; writes are taken every cycle while busy is low.
// A query reads its four neighbours through the single memory port, one per cycle; busy stays
// high after a query is taken so that the next item reaches the port only after the last read.
// Results keep query order.
// Reset is synchronous and clears the pipeline and the registers, not the grid memory.
// The receiver cannot stall; results are never held back.
module heightmap_bilinear_sampler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_command,
    input  logic [hbs_pkg::IDX_W-1:0]       i_cell_column,
    input  logic [hbs_pkg::IDX_W-1:0]       i_cell_row,
    input  logic signed [hbs_pkg::H_W-1:0]  i_cell_height,
    input  logic signed [hbs_pkg::H_W-1:0]  i_query_x,
    input  logic signed [hbs_pkg::H_W-1:0]  i_query_y,
    output logic                            o_sampled_valid,
    output logic signed [hbs_pkg::H_W-1:0]  o_sampled_height,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hbs_pkg::PADDR_W-1:0]     paddr,
    input  logic [hbs_pkg::PDATA_W-1:0]     pwdata,
    output logic [hbs_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    // configuration
    logic [hbs_pkg::H_W-1:0]          r_inv_cell_size;
    logic signed [hbs_pkg::H_W-1:0]   r_vertical_gain;
    logic signed [hbs_pkg::H_W-1:0]   r_height_offset;
    logic [hbs_pkg::DIM_W-1:0]        r_grid_width;
    logic [hbs_pkg::DIM_W-1:0]        r_grid_height;
    logic [hbs_pkg::DIM_W-1:0]        w_dim_x;
    logic [hbs_pkg::DIM_W-1:0]        w_dim_y;
    logic                             w_cfg_wr;
    hbs_pkg::t_reg                    w_reg_sel;

    // acceptance
    logic                             w_accept;
    logic                             w_acc_sample;
    logic [hbs_pkg::GAP_W-1:0]        r_gap_cnt;

    // stage 1: registered command
    logic                             r_s1_vld;
    hbs_pkg::t_cmd                    r_s1_cmd;
    logic [hbs_pkg::IDX_W-1:0]        r_s1_col;
    logic [hbs_pkg::IDX_W-1:0]        r_s1_row;
    logic signed [hbs_pkg::H_W-1:0]   r_s1_hgt;
    logic signed [hbs_pkg::H_W-1:0]   r_s1_qx;
    logic signed [hbs_pkg::H_W-1:0]   r_s1_qy;

    // stage 2: scaled positions
    logic                             r_s2_vld;
    hbs_pkg::t_cmd                    r_s2_cmd;
    logic [hbs_pkg::IDX_W-1:0]        r_s2_col;
    logic [hbs_pkg::IDX_W-1:0]        r_s2_row;
    logic signed [hbs_pkg::H_W-1:0]   r_s2_hgt;
    logic signed [hbs_pkg::PROD_W-1:0] r_s2_px;
    logic signed [hbs_pkg::PROD_W-1:0] r_s2_py;
    logic signed [hbs_pkg::PROD_W-1:0] n_s2_px;
    logic signed [hbs_pkg::PROD_W-1:0] n_s2_py;
    hbs_pkg::t_loc                    w_loc_x;
    hbs_pkg::t_loc                    w_loc_y;

    // stage 3: memory port sequencer
    logic                             r_s3_act;
    hbs_pkg::t_cmd                    r_s3_cmd;
    hbs_pkg::t_nb                     r_s3_cnt;
    logic [hbs_pkg::IDX_W-1:0]        r_s3_x0;
    logic [hbs_pkg::IDX_W-1:0]        r_s3_x1;
    logic [hbs_pkg::IDX_W-1:0]        r_s3_y0;
    logic [hbs_pkg::IDX_W-1:0]        r_s3_y1;
    logic [hbs_pkg::FRAC_W-1:0]       r_s3_fx;
    logic [hbs_pkg::FRAC_W-1:0]       r_s3_fy;
    logic [hbs_pkg::H_W-1:0]          r_s3_wdata;
    logic                             w_ram_we;
    logic                             w_ram_re;
    logic [hbs_pkg::ADDR_W-1:0]       w_ram_addr;
    logic [hbs_pkg::H_W-1:0]          w_ram_rdata;

    // height scaling pipeline
    logic                             r_m1_vld;
    hbs_pkg::t_tag                    r_m1_tag;
    logic                             r_m2_vld;
    hbs_pkg::t_tag                    r_m2_tag;
    logic signed [hbs_pkg::D_W-1:0]   r_m2_d;
    logic                             r_m3_vld;
    hbs_pkg::t_tag                    r_m3_tag;
    logic signed [hbs_pkg::PROD_W-1:0] r_m3_prod;
    logic signed [hbs_pkg::PROD_W-1:0] n_m3_prod;
    logic                             r_m4_vld;
    hbs_pkg::t_tag                    r_m4_tag;
    logic signed [hbs_pkg::SC_W-1:0]  r_m4_sc;
    logic signed [hbs_pkg::PROD_W-1:0] n_m4_rnd;
    logic signed [hbs_pkg::SC_W-1:0]  r_hold_a;
    logic                             w_row_go;

    // row blend along x
    logic                             r_rl1_vld;
    logic                             r_rl1_bot;
    logic [hbs_pkg::FRAC_W-1:0]       r_rl1_f;
    logic [hbs_pkg::FRAC_W-1:0]       r_rl1_fy;
    logic signed [hbs_pkg::SC_W-1:0]  r_rl1_a;
    logic signed [hbs_pkg::SCD_W-1:0] r_rl1_diff;
    logic                             r_rl2_vld;
    logic                             r_rl2_bot;
    logic [hbs_pkg::FRAC_W-1:0]       r_rl2_fy;
    logic signed [hbs_pkg::SC_W-1:0]  r_rl2_a;
    logic signed [hbs_pkg::LM_W-1:0]  r_rl2_m;
    logic signed [hbs_pkg::LM_W-1:0]  n_rl2_m;
    logic                             r_rl3_vld;
    logic                             r_rl3_bot;
    logic [hbs_pkg::FRAC_W-1:0]       r_rl3_fy;
    logic signed [hbs_pkg::SC_W-1:0]  r_rl3_res;
    logic signed [hbs_pkg::SC_W-1:0]  r_top;
    logic                             w_col_go;

    // column blend along y
    logic                             r_yl1_vld;
    logic [hbs_pkg::FRAC_W-1:0]       r_yl1_f;
    logic signed [hbs_pkg::SC_W-1:0]  r_yl1_a;
    logic signed [hbs_pkg::SCD_W-1:0] r_yl1_diff;
    logic                             r_yl2_vld;
    logic signed [hbs_pkg::SC_W-1:0]  r_yl2_a;
    logic signed [hbs_pkg::LM_W-1:0]  r_yl2_m;
    logic signed [hbs_pkg::LM_W-1:0]  n_yl2_m;
    logic                             r_yl3_vld;
    logic signed [hbs_pkg::SC_W-1:0]  r_yl3_res;

    logic                             r_out_vld;
    logic signed [hbs_pkg::H_W-1:0]   r_out_h;

    // ---------------------------------------------------------------- configuration port
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_sel = hbs_pkg::t_reg'(paddr[hbs_pkg::PADDR_W-1:2]);
    assign w_dim_x   = hbs_pkg::clamp_dim(r_grid_width);
    assign w_dim_y   = hbs_pkg::clamp_dim(r_grid_height);

    always_comb begin
        unique case (w_reg_sel)
            hbs_pkg::REG_INV_CELL_SIZE: prdata = r_inv_cell_size;
            hbs_pkg::REG_VERTICAL_GAIN: prdata = r_vertical_gain;
            hbs_pkg::REG_HEIGHT_OFFSET: prdata = r_height_offset;
            hbs_pkg::REG_GRID_WIDTH:    prdata = hbs_pkg::PDATA_W'(r_grid_width);
            hbs_pkg::REG_GRID_HEIGHT:   prdata = hbs_pkg::PDATA_W'(r_grid_height);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_cell_size <= hbs_pkg::INV_CELL_RST;
            r_vertical_gain <= hbs_pkg::GAIN_RST;
            r_height_offset <= hbs_pkg::OFFSET_RST;
            r_grid_width    <= hbs_pkg::DIM_W'(hbs_pkg::MAX_SIDE);
            r_grid_height   <= hbs_pkg::DIM_W'(hbs_pkg::MAX_SIDE);
        end else if (w_cfg_wr) begin
            unique case (w_reg_sel)
                hbs_pkg::REG_INV_CELL_SIZE: r_inv_cell_size <= pwdata[hbs_pkg::H_W-1:0];
                hbs_pkg::REG_VERTICAL_GAIN: r_vertical_gain <= pwdata[hbs_pkg::H_W-1:0];
                hbs_pkg::REG_HEIGHT_OFFSET: r_height_offset <= pwdata[hbs_pkg::H_W-1:0];
                hbs_pkg::REG_GRID_WIDTH:    r_grid_width    <= pwdata[hbs_pkg::DIM_W-1:0];
                hbs_pkg::REG_GRID_HEIGHT:   r_grid_height   <= pwdata[hbs_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- acceptance
    // every item meets the memory port at the same offset; a query owns it for all four neighbour reads
    assign busy         = (r_gap_cnt != '0);
    assign w_accept     = start && !busy;
    assign w_acc_sample = w_accept && (hbs_pkg::t_cmd'(i_command) == hbs_pkg::CMD_SAMPLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_cnt <= '0;
        end else if (w_acc_sample) begin
            r_gap_cnt <= hbs_pkg::GAP_W'(hbs_pkg::PORT_SLOTS - 1);
        end else if (r_gap_cnt != '0) begin
            r_gap_cnt <= r_gap_cnt - hbs_pkg::GAP_W'(1);
        end
    end

    // ---------------------------------------------------------------- front stages
    assign n_s2_px = r_s1_qx * $signed({1'b0, r_inv_cell_size});
    assign n_s2_py = r_s1_qy * $signed({1'b0, r_inv_cell_size});
    assign w_loc_x = hbs_pkg::locate(r_s2_px, w_dim_x);
    assign w_loc_y = hbs_pkg::locate(r_s2_py, w_dim_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_act <= 1'b0;
            r_s3_cnt <= hbs_pkg::NB_X0Y0;
        end else begin
            r_s1_vld <= w_accept;
            r_s2_vld <= r_s1_vld;
            if (r_s2_vld) begin
                r_s3_act <= 1'b1;
                r_s3_cnt <= hbs_pkg::NB_X0Y0;
            end else if (r_s3_act) begin
                if (r_s3_cmd == hbs_pkg::CMD_WRITE || r_s3_cnt == hbs_pkg::NB_X1Y1) begin
                    r_s3_act <= 1'b0;
                end
                r_s3_cnt <= hbs_pkg::t_nb'(r_s3_cnt + 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_cmd <= hbs_pkg::t_cmd'(i_command);
            r_s1_col <= i_cell_column;
            r_s1_row <= i_cell_row;
            r_s1_hgt <= i_cell_height;
            r_s1_qx  <= i_query_x;
            r_s1_qy  <= i_query_y;
        end
        if (r_s1_vld) begin
            r_s2_cmd <= r_s1_cmd;
            r_s2_col <= r_s1_col;
            r_s2_row <= r_s1_row;
            r_s2_hgt <= r_s1_hgt;
            r_s2_px  <= n_s2_px;
            r_s2_py  <= n_s2_py;
        end
        if (r_s2_vld) begin
            r_s3_cmd   <= r_s2_cmd;
            r_s3_wdata <= r_s2_hgt;
            r_s3_fx    <= w_loc_x.frac;
            r_s3_fy    <= w_loc_y.frac;
            r_s3_x1    <= w_loc_x.hi;
            r_s3_y1    <= w_loc_y.hi;
            // a write keeps its cell in the lower-corner slot
            if (r_s2_cmd == hbs_pkg::CMD_WRITE) begin
                r_s3_x0 <= r_s2_col;
                r_s3_y0 <= r_s2_row;
            end else begin
                r_s3_x0 <= w_loc_x.lo;
                r_s3_y0 <= w_loc_y.lo;
            end
        end
    end

    // ---------------------------------------------------------------- grid memory
    assign w_ram_we = r_s3_act && (r_s3_cmd == hbs_pkg::CMD_WRITE);
    assign w_ram_re = r_s3_act && (r_s3_cmd == hbs_pkg::CMD_SAMPLE);

    always_comb begin
        unique case (r_s3_cnt)
            hbs_pkg::NB_X0Y0: w_ram_addr = {r_s3_y0, r_s3_x0};
            hbs_pkg::NB_X1Y0: w_ram_addr = {r_s3_y0, r_s3_x1};
            hbs_pkg::NB_X0Y1: w_ram_addr = {r_s3_y1, r_s3_x0};
            hbs_pkg::NB_X1Y1: w_ram_addr = {r_s3_y1, r_s3_x1};
            default:          w_ram_addr = {r_s3_y0, r_s3_x0};
        endcase
    end

    hbs_ram #(
        .WIDTH (hbs_pkg::H_W),
        .DEPTH (hbs_pkg::DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_re    (w_ram_re),
        .i_addr  (w_ram_addr),
        .i_wdata (r_s3_wdata),
        .o_rdata (w_ram_rdata)
    );

    // ---------------------------------------------------------------- height scaling
    assign n_m3_prod = r_m2_d * r_vertical_gain;
    assign n_m4_rnd  = r_m3_prod + $signed(hbs_pkg::PROD_W'(1) << (hbs_pkg::FRAC_W - 1));
    assign w_row_go  = r_m4_vld && r_m4_tag.idx[0];
    assign w_col_go  = r_rl3_vld && r_rl3_bot;
    assign n_rl2_m   = r_rl1_diff * $signed({1'b0, r_rl1_f});
    assign n_yl2_m   = r_yl1_diff * $signed({1'b0, r_yl1_f});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld  <= 1'b0;
            r_m2_vld  <= 1'b0;
            r_m3_vld  <= 1'b0;
            r_m4_vld  <= 1'b0;
            r_rl1_vld <= 1'b0;
            r_rl2_vld <= 1'b0;
            r_rl3_vld <= 1'b0;
            r_yl1_vld <= 1'b0;
            r_yl2_vld <= 1'b0;
            r_yl3_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_m1_vld  <= w_ram_re;
            r_m2_vld  <= r_m1_vld;
            r_m3_vld  <= r_m2_vld;
            r_m4_vld  <= r_m3_vld;
            r_rl1_vld <= w_row_go;
            r_rl2_vld <= r_rl1_vld;
            r_rl3_vld <= r_rl2_vld;
            r_yl1_vld <= w_col_go;
            r_yl2_vld <= r_yl1_vld;
            r_yl3_vld <= r_yl2_vld;
            r_out_vld <= r_yl3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1_tag  <= '{idx: r_s3_cnt, fx: r_s3_fx, fy: r_s3_fy};
        r_m2_tag  <= r_m1_tag;
        r_m2_d    <= hbs_pkg::D_W'($signed(w_ram_rdata)) - hbs_pkg::D_W'(r_height_offset);
        r_m3_tag  <= r_m2_tag;
        r_m3_prod <= n_m3_prod;
        r_m4_tag  <= r_m3_tag;
        r_m4_sc   <= n_m4_rnd[hbs_pkg::PROD_W-1:hbs_pkg::FRAC_W];

        // hold the lower-column value until its partner arrives
        if (r_m4_vld && !r_m4_tag.idx[0]) begin
            r_hold_a <= r_m4_sc;
        end

        r_rl1_bot  <= (r_m4_tag.idx == hbs_pkg::NB_X1Y1);
        r_rl1_f    <= r_m4_tag.fx;
        r_rl1_fy   <= r_m4_tag.fy;
        r_rl1_a    <= r_hold_a;
        r_rl1_diff <= hbs_pkg::SCD_W'(r_m4_sc) - hbs_pkg::SCD_W'(r_hold_a);
        r_rl2_bot  <= r_rl1_bot;
        r_rl2_fy   <= r_rl1_fy;
        r_rl2_a    <= r_rl1_a;
        r_rl2_m    <= n_rl2_m;
        r_rl3_bot  <= r_rl2_bot;
        r_rl3_fy   <= r_rl2_fy;
        r_rl3_res  <= hbs_pkg::lerp_round(r_rl2_a, r_rl2_m);

        if (r_rl3_vld && !r_rl3_bot) begin
            r_top <= r_rl3_res;
        end

        r_yl1_f    <= r_rl3_fy;
        r_yl1_a    <= r_top;
        r_yl1_diff <= hbs_pkg::SCD_W'(r_rl3_res) - hbs_pkg::SCD_W'(r_top);
        r_yl2_a    <= r_yl1_a;
        r_yl2_m    <= n_yl2_m;
        r_yl3_res  <= hbs_pkg::lerp_round(r_yl2_a, r_yl2_m);
        r_out_h    <= hbs_pkg::sat_h(r_yl3_res);
    end

    assign o_sampled_valid  = r_out_vld;
    assign o_sampled_height = r_out_h;

    // ---------------------------------------------------------------- assertions
    a_result_follows_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_sample |-> ##(hbs_pkg::RESULT_LAT) o_sampled_valid)
        else $error("query transfer without result at fixed latency");

    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sampled_valid |-> $past(w_acc_sample, hbs_pkg::RESULT_LAT))
        else $error("result without matching query transfer");

    a_port_not_shared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_act && r_s3_cmd == hbs_pkg::CMD_SAMPLE && r_s3_cnt != hbs_pkg::NB_X1Y1)
        |-> !r_s2_vld)
        else $error("item reached the memory port while a query still reads");

endmodule

// ----- tb/sv/heightmap_bilinear_sampler_checker.sv -----
// Checker for the heightmap bilinear sampler: tracks grid and registers, predicts and compares.
module heightmap_bilinear_sampler_checker
    import hbs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  logic                   i_command,
    input  logic [IDX_W-1:0]       i_cell_column,
    input  logic [IDX_W-1:0]       i_cell_row,
    input  logic signed [H_W-1:0]  i_cell_height,
    input  logic signed [H_W-1:0]  i_query_x,
    input  logic signed [H_W-1:0]  i_query_y,
    input  logic                   i_sampled_valid,
    input  logic signed [H_W-1:0]  i_sampled_height,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [PADDR_W-1:0]     i_paddr,
    input  logic [PDATA_W-1:0]     i_pwdata,
    input  logic                   i_pready,
    output int                     o_error_count,
    output int                     o_pending_count
);

    localparam longint ONE = 65536;

    logic signed [H_W-1:0] height_copy [DEPTH];
    logic [H_W-1:0]        inv_cell;
    logic signed [H_W-1:0] gain;
    logic signed [H_W-1:0] offset;
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;
    logic signed [H_W-1:0] expected_heights [$];
    logic signed [H_W-1:0] want;
    int                    errors = 0;

    function automatic int unsigned side_in_use(input logic [DIM_W-1:0] d);
        if (d < 2) return 2;
        if (d > MAX_SIDE) return MAX_SIDE;
        return d;
    endfunction

    function automatic int clamp_to_side(input longint i, input int unsigned side);
        if (i < 0) return 0;
        if (i > longint'(side) - 1) return side - 1;
        return int'(i);
    endfunction

    // nearest, ties upward
    function automatic longint round16(input longint v);
        return (v + ONE / 2) >>> FRAC_W;
    endfunction

    function automatic void map_axis(input logic signed [H_W-1:0] q, input int unsigned side,
                                     output int lo, output int hi, output longint frac);
        longint prod;
        longint p;
        longint ip;
        prod = longint'(q) * longint'({32'd0, inv_cell});
        p    = (prod >>> FRAC_W) + longint'(side / 2) * ONE;
        ip   = p >>> FRAC_W;
        frac = p - ip * ONE;
        lo   = clamp_to_side(ip, side);
        hi   = clamp_to_side((frac != 0) ? ip + 1 : ip, side);
    endfunction

    function automatic longint scaled_height(input int col, input int row);
        longint d;
        d = longint'(height_copy[row * MAX_SIDE + col]) - longint'(offset);
        return round16(d * longint'(gain));
    endfunction

    function automatic longint blend_pair(input longint a, input longint b, input longint f);
        return round16(a * (ONE - f) + b * f);
    endfunction

    function automatic logic signed [H_W-1:0] blend_height(input logic signed [H_W-1:0] qx,
                                                           input logic signed [H_W-1:0] qy);
        int     x0;
        int     x1;
        int     y0;
        int     y1;
        longint fx;
        longint fy;
        longint top;
        longint bot;
        longint r;
        map_axis(qx, side_in_use(width_reg), x0, x1, fx);
        map_axis(qy, side_in_use(height_reg), y0, y1, fy);
        top = blend_pair(scaled_height(x0, y0), scaled_height(x1, y0), fx);
        bot = blend_pair(scaled_height(x0, y1), scaled_height(x1, y1), fx);
        r   = blend_pair(top, bot, fy);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[H_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            inv_cell   = INV_CELL_RST;
            gain       = GAIN_RST;
            offset     = OFFSET_RST;
            width_reg  = DIM_W'(MAX_SIDE);
            height_reg = DIM_W'(MAX_SIDE);
            expected_heights.delete();
            errors     = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_W-1:2])
                    REG_INV_CELL_SIZE: inv_cell   = i_pwdata;
                    REG_VERTICAL_GAIN: gain       = i_pwdata;
                    REG_HEIGHT_OFFSET: offset     = i_pwdata;
                    REG_GRID_WIDTH:    width_reg  = i_pwdata[DIM_W-1:0];
                    REG_GRID_HEIGHT:   height_reg = i_pwdata[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_sampled_valid) begin
                if (expected_heights.size() == 0) begin
                    $display("%0t: sampled_height %0d arrived with nothing pending",
                             $time, i_sampled_height);
                    errors++;
                end else begin
                    want = expected_heights.pop_front();
                    if (want !== i_sampled_height) begin
                        $display("%0t: sampled_height mismatch: expected %0d, actual %0d",
                                 $time, want, i_sampled_height);
                        errors++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (t_cmd'(i_command) == CMD_WRITE) begin
                    height_copy[{i_cell_row, i_cell_column}] = i_cell_height;
                end else begin
                    expected_heights.push_back(blend_height(i_query_x, i_query_y));
                end
            end
        end
        o_error_count   <= errors;
        o_pending_count <= expected_heights.size();
    end

endmodule

// ----- tb/sv/heightmap_bilinear_sampler_test.sv -----
// Top of the heightmap bilinear sampler testbench: clock, reset, stimulus and verdict.
module heightmap_bilinear_sampler_test;
    import hbs_pkg::*;

    localparam int         CLK_PERIOD   = 20;
    localparam int         LIMIT_CYCLES = 1_000_000;
    localparam logic [2:0] UNUSED_REG   = 3'(int'(REG_GRID_HEIGHT) + 1);

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  start         = 1'b0;
    logic                  busy;
    logic                  i_command     = CMD_WRITE;
    logic [IDX_W-1:0]      i_cell_column = '0;
    logic [IDX_W-1:0]      i_cell_row    = '0;
    logic signed [H_W-1:0] i_cell_height = '0;
    logic signed [H_W-1:0] i_query_x     = '0;
    logic signed [H_W-1:0] i_query_y     = '0;
    logic                  o_sampled_valid;
    logic signed [H_W-1:0] o_sampled_height;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [PADDR_W-1:0]    paddr         = '0;
    logic [PDATA_W-1:0]    pwdata        = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    int                    error_count;
    int                    pending_count;

    // stimulus shaping
    int                    burst_left = 1;
    int                    max_burst  = 8;
    int                    max_gap    = 4;
    logic [H_W-1:0]        cur_inv    = INV_CELL_RST;
    int unsigned           cur_w      = MAX_SIDE;
    int unsigned           cur_h      = MAX_SIDE;

    heightmap_bilinear_sampler u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_cell_column    (i_cell_column),
        .i_cell_row       (i_cell_row),
        .i_cell_height    (i_cell_height),
        .i_query_x        (i_query_x),
        .i_query_y        (i_query_y),
        .o_sampled_valid  (o_sampled_valid),
        .o_sampled_height (o_sampled_height),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    heightmap_bilinear_sampler_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_command        (i_command),
        .i_cell_column    (i_cell_column),
        .i_cell_row       (i_cell_row),
        .i_cell_height    (i_cell_height),
        .i_query_x        (i_query_x),
        .i_query_y        (i_query_y),
        .i_sampled_valid  (o_sampled_valid),
        .i_sampled_height (o_sampled_height),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_pready         (pready),
        .o_error_count    (error_count),
        .o_pending_count  (pending_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int unsigned side_of(input logic [DIM_W-1:0] d);
        if (d < 2) return 2;
        if (d > MAX_SIDE) return MAX_SIDE;
        return d;
    endfunction

    function automatic logic [H_W-1:0] pick_height();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_side();
        case ($urandom_range(0, 9))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd2;
            3:       return 9'd3;
            4:       return 9'd256;
            5:       return 9'd257;
            6:       return 9'd511;
            7, 8:    return 9'($urandom_range(2, 32));
            default: return 9'($urandom_range(2, MAX_SIDE));
        endcase
    endfunction

    // aim most coordinates at the grid in use, the rest anywhere
    function automatic logic [H_W-1:0] pick_coord(input int unsigned side);
        longint target;
        longint rel;
        longint q;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2: return $urandom;
            default: begin
                if (cur_inv == 0) return $urandom;
                target = longint'($urandom_range(0, (side + 3) * 65536)) - 2 * 65536;
                rel    = target - longint'(side / 2) * 65536;
                q      = (rel * 65536) / longint'({32'd0, cur_inv});
                if ($urandom_range(0, 3) == 0) q = q & ~longint'(65535);
                if (q > 64'sd2147483647) q = 64'sd2147483647;
                if (q < -64'sd2147483648) q = -64'sd2147483648;
                return q[H_W-1:0];
            end
        endcase
    endfunction

    task automatic send_item(input t_cmd cmd, input logic [IDX_W-1:0] col,
                             input logic [IDX_W-1:0] row, input logic [H_W-1:0] hgt,
                             input logic [H_W-1:0] qx, input logic [H_W-1:0] qy);
        int gap;
        start         <= 1'b1;
        i_command     <= cmd;
        i_cell_column <= col;
        i_cell_row    <= row;
        i_cell_height <= hgt;
        i_query_x     <= qx;
        i_query_y     <= qy;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, max_burst);
            gap        = $urandom_range(0, max_gap);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic put_cell(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row,
                            input logic [H_W-1:0] hgt);
        send_item(CMD_WRITE, col, row, hgt, $urandom, $urandom);
    endtask

    task automatic sample_at(input logic [H_W-1:0] qx, input logic [H_W-1:0] qy);
        send_item(CMD_SAMPLE, 8'($urandom), 8'($urandom), $urandom, qx, qy);
    endtask

    // drop start, drain the results, then let the grid writes settle
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (RESULT_LAT + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [H_W-1:0] inv, input logic [H_W-1:0] gain,
                             input logic [H_W-1:0] offset, input logic [DIM_W-1:0] w,
                             input logic [DIM_W-1:0] h);
        wait_idle();
        write_reg(REG_INV_CELL_SIZE, inv);
        write_reg(REG_VERTICAL_GAIN, gain);
        write_reg(REG_HEIGHT_OFFSET, offset);
        // upper bits lie outside the register and must be dropped
        write_reg(REG_GRID_WIDTH, {23'($urandom), w});
        write_reg(REG_GRID_HEIGHT, {23'($urandom), h});
        cur_inv = inv;
        cur_w   = side_of(w);
        cur_h   = side_of(h);
    endtask

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [H_W-1:0]   inv_pick;
        logic [H_W-1:0]   gain_pick;
        logic [H_W-1:0]   offset_pick;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole grid so that no query reads an unwritten cell
        max_burst = 256;
        max_gap   = 2;
        for (int r = 0; r < MAX_SIDE; r++) begin
            for (int c = 0; c < MAX_SIDE; c++) begin
                put_cell(8'(c), 8'(r), pick_height());
            end
        end

        max_burst = 12;
        max_gap   = 6;

        // reset settings: centre, far edges, negative and tiny fractions
        sample_at(32'h0000_0000, 32'h0000_0000);
        sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        sample_at(32'h8000_0000, 32'h8000_0000);
        sample_at(32'h7FFF_FFFF, 32'h8000_0000);
        sample_at(32'h0000_8000, 32'hFFFF_8000);
        sample_at(32'h0000_0001, 32'hFFFF_FFFF);
        put_cell(8'd0, 8'd0, 32'h7FFF_FFFF);
        put_cell(8'd255, 8'd255, 32'h8000_0000);
        put_cell(8'd1, 8'd0, 32'h8000_0000);
        put_cell(8'd0, 8'd1, 32'h7FFF_FFFF);
        sample_at(32'hFF80_8000, 32'hFF80_8000);
        sample_at(32'h8000_0000, 32'h7FFF_FFFF);
        sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);

        // extreme gain and offset drive the blend into saturation
        configure(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 9'd0, 9'd511);
        write_reg(UNUSED_REG, $urandom);
        sample_at(32'h0000_0000, 32'h0000_0000);
        sample_at(32'h0000_0001, 32'hFFFF_FFFF);
        sample_at(32'h8000_0000, 32'h7FFF_FFFF);
        put_cell(8'd1, 8'd1, 32'h8000_0000);
        sample_at(32'h0001_0000, 32'h0000_0000);

        configure(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 9'd1, 9'd257);
        sample_at($urandom, $urandom);
        sample_at($urandom, $urandom);

        for (int ph = 0; ph < 12; ph++) begin
            case ($urandom_range(0, 4))
                0:       inv_pick = 32'h0000_0000;
                1:       inv_pick = 32'hFFFF_FFFF;
                2:       inv_pick = INV_CELL_RST;
                3:       inv_pick = $urandom_range(1, 32'h0004_0000);
                default: inv_pick = $urandom;
            endcase
            case ($urandom_range(0, 4))
                0:       gain_pick = 32'h7FFF_FFFF;
                1:       gain_pick = 32'h8000_0000;
                2:       gain_pick = GAIN_RST;
                3:       gain_pick = $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
                default: gain_pick = $urandom;
            endcase
            case ($urandom_range(0, 4))
                0:       offset_pick = 32'h7FFF_FFFF;
                1:       offset_pick = 32'h8000_0000;
                2:       offset_pick = OFFSET_RST;
                3:       offset_pick = $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
                default: offset_pick = $urandom;
            endcase
            configure(inv_pick, gain_pick, offset_pick, pick_side(), pick_side());
            if ($urandom_range(0, 2) == 0) write_reg(UNUSED_REG + 3'($urandom_range(0, 2)),
                                                     $urandom);
            repeat (50) begin
                if ($urandom_range(0, 9) < 3) begin
                    if ($urandom_range(0, 4) == 0) begin
                        col = 8'($urandom);
                        row = 8'($urandom);
                    end else begin
                        col = 8'($urandom_range(0, cur_w - 1));
                        row = 8'($urandom_range(0, cur_h - 1));
                    end
                    put_cell(col, row, pick_height());
                end else begin
                    sample_at(pick_coord(cur_w), pick_coord(cur_h));
                end
            end
        end

        wait_idle();
        if (error_count == 0 && pending_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/hbs_pkg.sv
hdl/hbs_ram.sv
hdl/heightmap_bilinear_sampler.sv
tb/sv/heightmap_bilinear_sampler_checker.sv
tb/sv/heightmap_bilinear_sampler_test.sv
